// ===== rtl/core/a2c_pkg.sv =====
`default_nettype none
package a2c_pkg;

  localparam int LEN_BITS_DEFAULT = 16;
  localparam int OUT_MAX = 65535;

  // column commands
  localparam logic [1:0] CMD_PAIR = 2'd0;
  localparam logic [1:0] CMD_DEL = 2'd1;
  localparam logic [1:0] CMD_INS = 2'd2;
  localparam logic [1:0] CMD_FINISH = 2'd3;

  // cigar operation kinds
  localparam logic [2:0] KIND_MATCH = 3'd0;
  localparam logic [2:0] KIND_MISM = 3'd1;
  localparam logic [2:0] KIND_INS = 3'd2;
  localparam logic [2:0] KIND_DEL = 3'd3;
  localparam logic [2:0] KIND_CLIP = 3'd4;
  localparam logic [2:0] KIND_NONE = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_START = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LENGTH = 8'd1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] read_base;
    logic [7:0] ref_base;
  } column_t;

  typedef struct packed {
    logic [2:0] op_kind;
    logic [15:0] run_length;
    logic [15:0] mismatch_total;
    logic last;
  } cigar_op_t;

endpackage
`default_nettype wire

// ===== rtl/core/alignment_to_cigar_encoder.sv =====
`default_nettype none
// Extended CIGAR run-length encoder.
// Input channel (in_valid / in_stall / in_data) takes one alignment column per
// request: aligned pair, deletion, insertion or finish. Output channel
// (out_valid / out_stall / out_data) delivers CIGAR runs; the last result of a
// finish request carries last and the final mismatch total.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets clip_start
// (index 0) and read_length (index 1); cfg_ready is always high. Write it only
// while the block is idle.
// A request is registered at acceptance and, once the queue holds at most two
// results, is processed into a 4-entry queue that drives out_data directly.
// Throughput: one request per cycle while in_stall is low. A column request
// makes at most one result, a finish request one or two; the queue drains one
// result per cycle when out_stall is low. in_stall rises while a request waits
// and the queue holds more than two results: under receiver stalls, or after
// back-to-back finish requests that each make two results; results are held
// in order, none lost.
// Reset (rst, synchronous) clears the run state, both registers and the queue.
module alignment_to_cigar_encoder #(
  parameter int LEN_BITS = a2c_pkg::LEN_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire a2c_pkg::column_t                 in_data,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      a2c_pkg::cigar_op_t               out_data,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [a2c_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                      cfg_data
);
  import a2c_pkg::*;

  localparam int CW = LEN_BITS + 1;
  localparam int MW = (LEN_BITS > 16) ? LEN_BITS : 16;
  localparam int SW = MW + 2;
  localparam logic [SW-1:0] COV_MAX = SW'((64'd1 << CW) - 64'd1);
  localparam logic [MW-1:0] OUT_LIM = MW'(OUT_MAX);

  function automatic logic [15:0] clamp16(input logic [MW-1:0] v);
    logic [15:0] r;
    r = (v > OUT_LIM) ? 16'hFFFF : v[15:0];
    return r;
  endfunction

  // configuration
  logic [15:0] clip_start;
  logic [15:0] read_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_start <= '0;
      read_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CLIP_START) begin
        clip_start <= cfg_data;
      end else if (cfg_index == CFG_READ_LENGTH) begin
        read_length <= cfg_data;
      end
    end
  end

  // input register
  column_t item;
  logic    item_valid;
  logic    fire;

  // result queue
  cigar_op_t  q [4];
  logic [1:0] head;
  logic [1:0] tail;
  logic [2:0] count;
  logic       pop;

  assign fire = item_valid && (count <= 3'd2);
  assign in_stall = item_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  // run state
  logic [2:0]          open_kind;
  logic [LEN_BITS-1:0] open_count;
  logic [CW-1:0]       covered;
  logic [LEN_BITS-1:0] mism;
  logic                started;

  logic                is_finish;
  logic [2:0]          kind_in;
  logic [LEN_BITS-1:0] mism_next;
  logic                lead;
  logic                has_run;
  logic                has_x;
  logic [MW-1:0]       addend;
  logic [SW-1:0]       cov_sum;
  logic [SW-1:0]       cov_sat;
  logic                trail;
  logic [15:0]         trail_len;
  logic [15:0]         mism_out;
  cigar_op_t           res0;
  cigar_op_t           res1;
  logic                push2;
  logic [1:0]          push_n;

  always_comb begin
    is_finish = (item.cmd == CMD_FINISH);
    case (item.cmd)
      CMD_PAIR: kind_in = (item.read_base == item.ref_base) ? KIND_MATCH : KIND_MISM;
      CMD_DEL:  kind_in = KIND_DEL;
      CMD_INS:  kind_in = KIND_INS;
      default:  kind_in = KIND_NONE;
    endcase

    mism_next = mism;
    if (kind_in == KIND_MISM && mism != '1) begin
      mism_next = mism + 1'b1;
    end
    mism_out = clamp16(MW'(mism_next));

    lead = !started && (clip_start != 16'd0);
    // open run is flushed on a kind change or at finish
    has_run = (open_kind != KIND_NONE) && (open_count != '0)
              && (is_finish || open_kind != kind_in);
    has_x = lead || has_run;

    if (lead) begin
      addend = MW'(clip_start);
    end else if (has_run && open_kind != KIND_DEL) begin
      addend = MW'(open_count);
    end else begin
      addend = '0;
    end
    cov_sum = SW'(covered) + SW'(addend);
    cov_sat = (cov_sum > COV_MAX) ? COV_MAX : cov_sum;

    trail = is_finish && (cov_sat < SW'(read_length));
    trail_len = read_length - cov_sat[15:0];

    res1.op_kind = KIND_CLIP;
    res1.run_length = trail_len;
    res1.mismatch_total = mism_out;
    res1.last = 1'b1;

    res0.mismatch_total = mism_out;
    if (has_x) begin
      res0.op_kind = lead ? KIND_CLIP : open_kind;
      res0.run_length = lead ? clip_start : clamp16(MW'(open_count));
    end else if (trail) begin
      res0.op_kind = KIND_CLIP;
      res0.run_length = trail_len;
    end else begin
      res0.op_kind = KIND_NONE;
      res0.run_length = '0;
    end
    push2 = has_x && trail;
    res0.last = is_finish && !push2;

    if (is_finish) begin
      push_n = push2 ? 2'd2 : 2'd1;
    end else begin
      push_n = has_x ? 2'd1 : 2'd0;
    end
    if (!fire) begin
      push_n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_kind <= KIND_NONE;
      open_count <= '0;
      covered <= '0;
      mism <= '0;
      started <= 1'b0;
    end else if (fire) begin
      if (is_finish) begin
        open_kind <= KIND_NONE;
        open_count <= '0;
        covered <= '0;
        mism <= '0;
        started <= 1'b0;
      end else begin
        open_kind <= kind_in;
        if (open_kind != kind_in) begin
          open_count <= LEN_BITS'(1);
        end else if (open_count != '1) begin
          open_count <= open_count + 1'b1;
        end
        covered <= cov_sat[CW-1:0];
        mism <= mism_next;
        started <= 1'b1;
      end
    end
  end

  assign out_valid = (count != 3'd0);
  assign out_data = q[head];
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + 2'd1;
      end
      tail <= tail + push_n;
      count <= count + 3'(push_n) - 3'(pop);
    end
    if (push_n != 2'd0) begin
      q[tail] <= res0;
    end
    if (push_n == 2'd2) begin
      q[tail + 2'd1] <= res1;
    end
  end

endmodule
`default_nettype wire
